FILE: rtl/core/sbsl_pkg.sv
// Shared types and constants for the sorted breakpoint segment locator.
package sbsl_pkg;

    localparam int unsigned DEPTH_DEF         = 64;
    localparam int unsigned KEY_WIDTH_DEF     = 32;
    localparam int unsigned PAYLOAD_WIDTH_DEF = 16;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned PAY_W    = 16;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_EVAL   = 2'd1,
        OP_DERIV  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_OUT  = 2'd3
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     segment_index;
        logic [PAY_W-1:0]     segment_payload;
        logic [COUNT_W-1:0]   entry_count;
    } t_result;

endpackage

FILE: rtl/core/sbsl_store.sv
// Breakpoint and payload memories with one write port and registered reads.
module sbsl_store
    import sbsl_pkg::*;
#(
    parameter int unsigned DEPTH         = DEPTH_DEF,
    parameter int unsigned KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [KEY_WIDTH-1:0]       i_wkey,
    input  logic [PAYLOAD_WIDTH-1:0]   i_wpay,
    input  logic [$clog2(DEPTH)-1:0]   i_key_raddr,
    input  logic [$clog2(DEPTH)-1:0]   i_pay_raddr,
    output logic [KEY_WIDTH-1:0]       o_key_rd,
    output logic [PAYLOAD_WIDTH-1:0]   o_pay_rd
);

    logic [KEY_WIDTH-1:0]     r_key_mem [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] r_pay_mem [DEPTH];
    logic [KEY_WIDTH-1:0]     r_key_rd;
    logic [PAYLOAD_WIDTH-1:0] r_pay_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_key_mem[i_waddr] <= i_wkey;
            r_pay_mem[i_waddr] <= i_wpay;
        end
        r_key_rd <= r_key_mem[i_key_raddr];
        r_pay_rd <= r_pay_mem[i_pay_raddr];
    end

    assign o_key_rd = r_key_rd;
    assign o_pay_rd = r_pay_rd;

endmodule

FILE: rtl/core/sbsl_ctrl.sv
// Sequencer for binary search, ordered insertion by shifting, and result formation.
module sbsl_ctrl
    import sbsl_pkg::*;
#(
    parameter int unsigned DEPTH         = DEPTH_DEF,
    parameter int unsigned KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [OP_W-1:0]            i_operation,
    input  logic [KEY_WIDTH-1:0]       i_position,
    input  logic [PAYLOAD_WIDTH-1:0]   i_payload,
    input  logic                       i_out_free,
    output logic                       o_busy,
    output logic                       o_res_valid,
    output t_result                    o_res,
    output logic                       o_we,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [KEY_WIDTH-1:0]       o_wkey,
    output logic [PAYLOAD_WIDTH-1:0]   o_wpay,
    output logic [$clog2(DEPTH)-1:0]   o_key_raddr,
    output logic [$clog2(DEPTH)-1:0]   o_pay_raddr,
    input  logic [KEY_WIDTH-1:0]       i_key_rd,
    input  logic [PAYLOAD_WIDTH-1:0]   i_pay_rd
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SRCH_RD  = 8'b0000_0010,
        S_SRCH_CMP = 8'b0000_0100,
        S_PROBE_RD = 8'b0000_1000,
        S_CHECK    = 8'b0001_0000,
        S_SHIFT_RD = 8'b0010_0000,
        S_SHIFT_WR = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_lo, n_lo;
    logic [CW-1:0]            r_hi, n_hi;
    logic [CW-1:0]            r_mid, n_mid;
    logic [CW-1:0]            r_i, n_i;
    logic [OP_W-1:0]          r_op;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_pay;
    t_result                  r_res, n_res;
    logic                     r_write_last, n_write_last;

    logic [CW:0]              w_sum;
    logic [CW-1:0]            w_pos_m1;
    logic [CW-1:0]            w_seg;
    logic [CW-1:0]            w_i_m1;
    logic                     w_hit;
    logic                     w_at_last;

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_pos_m1 = r_lo - CW'(1);
    assign w_i_m1   = r_i - CW'(1);
    assign w_at_last = (r_lo == r_count);
    // The derivative at the final breakpoint belongs to the segment before it.
    assign w_seg    = (t_op'(r_op) == OP_DERIV && w_at_last && w_pos_m1 != '0) ?
                      (r_lo - CW'(2)) : w_pos_m1;
    assign w_hit    = (r_lo != '0) && (i_key_rd == r_key);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_i          = r_i;
        n_res        = r_res;
        n_write_last = 1'b0;
        o_res_valid  = 1'b0;
        o_we         = 1'b0;
        o_waddr      = r_i[AW-1:0];
        o_wkey       = i_key_rd;
        o_wpay       = i_pay_rd;
        o_key_raddr  = w_i_m1[AW-1:0];
        o_pay_raddr  = w_i_m1[AW-1:0];

        if (r_write_last) begin
            o_we    = 1'b1;
            o_waddr = r_lo[AW-1:0];
            o_wkey  = r_key;
            o_wpay  = r_pay;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                o_key_raddr = w_sum[AW:1];
                n_mid       = w_sum[CW:1];
                if (r_lo < r_hi) begin
                    n_state = S_SRCH_CMP;
                end else begin
                    n_state = S_PROBE_RD;
                end
            end
            S_SRCH_CMP: begin
                if ($signed(r_key) < $signed(i_key_rd)) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
                n_state = S_SRCH_RD;
            end
            S_PROBE_RD: begin
                o_key_raddr = w_pos_m1[AW-1:0];
                o_pay_raddr = w_seg[AW-1:0];
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                n_res.entry_count = COUNT_W'(r_count);
                n_res.status      = ST_OUT;
                n_res.segment_index   = '0;
                n_res.segment_payload = '0;
                n_state = S_RESULT;
                unique case (t_op'(r_op))
                    OP_INSERT: begin
                        if (w_hit) begin
                            n_res.status        = ST_DUP;
                            n_res.segment_index = IDX_W'(w_pos_m1);
                        end else if (r_count == CW'(DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_res.status          = ST_OK;
                            n_res.segment_index   = IDX_W'(r_lo);
                            n_res.segment_payload = PAY_W'(r_pay);
                            n_res.entry_count     = COUNT_W'(r_count + CW'(1));
                            n_count               = r_count + CW'(1);
                            n_i                   = r_count;
                            if (r_count == r_lo) begin
                                n_write_last = 1'b1;
                            end else begin
                                n_state = S_SHIFT_RD;
                            end
                        end
                    end
                    OP_EVAL, OP_DERIV: begin
                        if (r_lo != '0 && !(w_at_last && !w_hit)) begin
                            n_res.status          = ST_OK;
                            n_res.segment_index   = IDX_W'(w_seg);
                            n_res.segment_payload = PAY_W'(i_pay_rd);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_we = 1'b1;
                n_i  = w_i_m1;
                if (w_i_m1 == r_lo) begin
                    n_write_last = 1'b1;
                    n_state      = S_RESULT;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_RESULT: begin
                if (!r_write_last && i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_write_last <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_write_last <= n_write_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_i   <= n_i;
        r_res <= n_res;
        if (i_start && r_state == S_IDLE) begin
            r_op  <= i_operation;
            r_key <= i_position;
            r_pay <= i_payload;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_res  = r_res;

endmodule

FILE: rtl/core/sorted_breakpoint_segment_locator.sv
// Top level of the sorted breakpoint segment locator with its output register.
//
// Usage: the table holds up to DEPTH signed breakpoints in ascending order, each
// with a payload handle. An input transaction carries an operation (insert,
// evaluate lookup, derivative lookup), a position and a payload. Every input
// transaction yields exactly one output transaction with status, segment index,
// segment payload and the number of stored breakpoints afterwards.
// Input channel: i_valid / o_stall. o_stall is high while an item is at work,
// so the block holds one item at a time. Output channel: o_valid / i_stall.
// A lookup runs a binary search over the n stored entries, alternating read and
// compare states, and then passes through the probe, check and result states.
// An insert moves each larger entry up one place, with a read state and a write
// state per entry, through the single memory write port, then writes the new entry.
// The next item is taken in the cycle after the result has been loaded.
// Reset (synchronous, active low) empties the table; the memory contents are
// not cleared, since only entries below the fill count are ever used.
// When the receiver stalls, the result waits in the output register and the
// sequencer holds its finished result until that register is free.
module sorted_breakpoint_segment_locator
    import sbsl_pkg::*;
#(
    parameter int unsigned DEPTH         = DEPTH_DEF,
    parameter int unsigned KEY_WIDTH     = KEY_WIDTH_DEF,
    parameter int unsigned PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [OP_W-1:0]            i_operation,
    input  logic [KEY_WIDTH-1:0]       i_position,
    input  logic [PAYLOAD_WIDTH-1:0]   i_payload,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [IDX_W-1:0]           o_segment_index,
    output logic [PAY_W-1:0]           o_segment_payload,
    output logic [COUNT_W-1:0]         o_entry_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                     w_busy;
    logic                     w_res_valid;
    t_result                  w_res;
    logic                     w_out_free;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [KEY_WIDTH-1:0]     w_wkey;
    logic [PAYLOAD_WIDTH-1:0] w_wpay;
    logic [AW-1:0]            w_key_raddr;
    logic [AW-1:0]            w_pay_raddr;
    logic [KEY_WIDTH-1:0]     w_key_rd;
    logic [PAYLOAD_WIDTH-1:0] w_pay_rd;

    logic                     r_out_valid;
    t_result                  r_out;

    // The output register can take a new result when it is empty or draining.
    assign w_out_free = !r_out_valid || !i_stall;

    sbsl_ctrl #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_valid),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_payload    (i_payload),
        .i_out_free   (w_out_free),
        .o_busy       (w_busy),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_we         (w_we),
        .o_waddr      (w_waddr),
        .o_wkey       (w_wkey),
        .o_wpay       (w_wpay),
        .o_key_raddr  (w_key_raddr),
        .o_pay_raddr  (w_pay_raddr),
        .i_key_rd     (w_key_rd),
        .i_pay_rd     (w_pay_rd)
    );

    sbsl_store #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (w_we),
        .i_waddr     (w_waddr),
        .i_wkey      (w_wkey),
        .i_wpay      (w_wpay),
        .i_key_raddr (w_key_raddr),
        .i_pay_raddr (w_pay_raddr),
        .o_key_rd    (w_key_rd),
        .o_pay_rd    (w_pay_rd)
    );

    // Output register: loaded from the sequencer, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_res_valid || (r_out_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_stall           = w_busy;
    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_segment_index   = r_out.segment_index;
    assign o_segment_payload = r_out.segment_payload;
    assign o_entry_count     = r_out.entry_count;

`ifndef NO_ASSERTIONS
    // A result is only handed over when the output register has room for it.
    a_res_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!r_out_valid || !i_stall))
        else $error("result loaded into an occupied output register");

    // A freshly accepted transaction cannot finish in the very next cycle.
    a_no_instant_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !w_res_valid)
        else $error("result produced without a search");

    // A handed-over result is visible on the output channel in the next cycle.
    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> o_valid)
        else $error("handed-over result not presented");
`endif

endmodule
